### hdl/hid_report_event_mapper_macros.svh
// ----------------------------------------------------------------------------
// HID report event mapper: assertion macros
// Shared concurrent assertion forms for the mapper's RTL checks.
// ----------------------------------------------------------------------------
`ifndef HID_REPORT_EVENT_MAPPER_MACROS_SVH
`define HID_REPORT_EVENT_MAPPER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HREM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define HREM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/hrem_pkg.sv
// ----------------------------------------------------------------------------
// HID report event mapper package
// Field widths, rule and result types, sequencer states and mask constants.
// ----------------------------------------------------------------------------
package hrem_pkg;

   localparam int DEF_RULE_COUNT   = 16;
   localparam int DEF_REPORT_BYTES = 64;
   localparam int MAX_RESULTS      = 16;

   localparam int POS_W   = 6;
   localparam int SLOT_W  = 4;
   localparam int KIND_W  = 3;
   localparam int BYTE_W  = 8;
   localparam int DEV_W   = 8;
   localparam int EVT_W   = 16;
   localparam int CFG_W   = 5;
   localparam int CNT_W   = 5;

   localparam logic [BYTE_W-1:0] LOW_NIBBLE  = 8'b0000_1111;
   localparam logic [BYTE_W-1:0] HIGH_NIBBLE = 8'b1111_0000;

   localparam logic MODE_BYTE = 1'b0;
   localparam logic MODE_RULE = 1'b1;

   localparam logic ACT_SET  = 1'b0;
   localparam logic ACT_EXEC = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      KIND_BIT        = 3'd0,
      KIND_VAR_LO     = 3'd1,
      KIND_VAR_HI     = 3'd2,
      KIND_VAR_BYTE   = 3'd3,
      KIND_MATCH_LO   = 3'd4,
      KIND_MATCH_HI   = 3'd5,
      KIND_MATCH_BYTE = 3'd6,
      KIND_NONE       = 3'd7
   } rule_kind_type;

   typedef struct packed {
      rule_kind_type     kind;
      logic [POS_W-1:0]  pos;
      logic [BYTE_W-1:0] arg;
      logic [DEV_W-1:0]  dev;
      logic [EVT_W-1:0]  evt;
   } rule_type;

   typedef struct packed {
      logic              action;
      logic [DEV_W-1:0]  device;
      logic [EVT_W-1:0]  target;
      logic [BYTE_W-1:0] value;
   } result_type;

   // shared evaluation unit outcome for one rule
   typedef struct packed {
      logic              fire;
      result_type        res;
      logic [BYTE_W-1:0] last_next;
   } eval_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RULE_RD,
      ST_BYTE_RD,
      ST_EVAL,
      ST_FLUSH
   } state_type;

endpackage

### hdl/hrem_report_mem.sv
// ----------------------------------------------------------------------------
// HID report event mapper: report byte store
// One write port, one registered read port. Per-entry valid bits make
// never-written bytes read as zero; positions past the store read as zero.
// ----------------------------------------------------------------------------
module hrem_report_mem #(
   parameter int REPORT_BYTES = hrem_pkg::DEF_REPORT_BYTES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [hrem_pkg::POS_W-1:0]  wr_pos,
   input  logic [hrem_pkg::BYTE_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [hrem_pkg::POS_W-1:0]  rd_pos,
   output logic [hrem_pkg::BYTE_W-1:0] rd_data
);
   import hrem_pkg::*;

   localparam int RPT_AW = (REPORT_BYTES > 1) ? $clog2(REPORT_BYTES) : 1;
   localparam int PW     = (RPT_AW > POS_W) ? RPT_AW : POS_W;

   logic [BYTE_W-1:0]       byte_mem [REPORT_BYTES];
   logic [REPORT_BYTES-1:0] valid_ff;
   logic [BYTE_W-1:0]       rd_data_ff;

   logic [PW-1:0]     wr_ext;
   logic [PW-1:0]     rd_ext;
   logic [RPT_AW-1:0] wr_addr;
   logic [RPT_AW-1:0] rd_addr;
   logic              wr_ok;
   logic              rd_ok;

   assign wr_ext  = PW'(wr_pos);
   assign rd_ext  = PW'(rd_pos);
   assign wr_addr = wr_ext[RPT_AW-1:0];
   assign rd_addr = rd_ext[RPT_AW-1:0];
   assign wr_ok   = {1'b0, wr_ext} < (PW+1)'(REPORT_BYTES);
   assign rd_ok   = {1'b0, rd_ext} < (PW+1)'(REPORT_BYTES);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en && wr_ok) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && wr_ok) begin
         byte_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (rd_ok && valid_ff[rd_addr]) begin
            rd_data_ff <= byte_mem[rd_addr];
         end else begin
            rd_data_ff <= '0;
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/hrem_rule_eval.sv
// ----------------------------------------------------------------------------
// HID report event mapper: rule evaluation unit
// Shared field extract and compare, applied to one rule per walk step.
// ----------------------------------------------------------------------------
module hrem_rule_eval (
   input  hrem_pkg::rule_type          rule,
   input  logic [hrem_pkg::BYTE_W-1:0] byte_val,
   input  logic [hrem_pkg::BYTE_W-1:0] last,
   output hrem_pkg::eval_type          result
);
   import hrem_pkg::*;

   logic [BYTE_W-1:0] lo_field;
   logic [BYTE_W-1:0] hi_field;
   logic [BYTE_W-1:0] field;
   logic              hit;
   logic              is_var;

   assign lo_field = byte_val & LOW_NIBBLE;
   assign hi_field = (byte_val & HIGH_NIBBLE) >> 4;

   always_comb begin
      field  = byte_val;
      hit    = 1'b0;
      is_var = 1'b0;
      case (rule.kind)
         KIND_BIT:        hit = byte_val[rule.arg[2:0]];
         KIND_VAR_LO:     begin field = lo_field; is_var = 1'b1; end
         KIND_VAR_HI:     begin field = hi_field; is_var = 1'b1; end
         KIND_VAR_BYTE:   is_var = 1'b1;
         KIND_MATCH_LO:   hit = (lo_field == rule.arg);
         KIND_MATCH_HI:   hit = (hi_field == rule.arg);
         KIND_MATCH_BYTE: hit = (byte_val == rule.arg);
         default:         hit = 1'b0;
      endcase
   end

   always_comb begin
      result.res.device = rule.dev;
      if (rule.kind == KIND_NONE) begin
         result.fire       = 1'b0;
         result.last_next  = last;
         result.res.action = ACT_SET;
         result.res.target = rule.evt;
         result.res.value  = '0;
      end else if (is_var) begin
         result.fire       = (last != field);
         result.last_next  = field;
         result.res.action = ACT_SET;
         result.res.target = EVT_W'(rule.arg);
         result.res.value  = field;
      end else begin
         // execute only on the rising edge of the match
         result.fire       = hit && (last == '0);
         result.last_next  = hit ? BYTE_W'(1) : '0;
         result.res.action = ACT_EXEC;
         result.res.target = rule.evt;
         result.res.value  = '0;
      end
   end

endmodule

### hdl/hid_report_event_mapper.sv
// ----------------------------------------------------------------------------
// HID report event mapper
// Stores report bytes and rules; at the end of a report walks the active
// rules through one shared evaluation unit and emits set/execute results.
//
//   channel | dir | handshake          | payload
//   req     | in  | req_valid/stall    | mode, byte/rule fields
//   rsp     | out | rsp_valid/stall    | action, dest_device, target, value, final
//   csr     | in  | csr_write_enable   | active_rules (5 bits)
//
// Rule writes and non-final report bytes are taken while the mapper is idle.
// A report end walks each active rule through rule read, byte read and
// evaluate, then sends the final result; a stalled rsp holds the walk longer.
// The walk is serialized by the single rule-store and report-store read ports.
// Synchronous reset clears the report store, last-seen values and active_rules.
// Input is stalled for the whole walk; a finished result waits in the output
// register without blocking the next transfer.
// ----------------------------------------------------------------------------
`include "hid_report_event_mapper_macros.svh"

module hid_report_event_mapper #(
   parameter int RULE_COUNT   = hrem_pkg::DEF_RULE_COUNT,
   parameter int REPORT_BYTES = hrem_pkg::DEF_REPORT_BYTES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [hrem_pkg::CFG_W-1:0]  csr_write_data,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_mode,
   input  logic [hrem_pkg::POS_W-1:0]  req_byte_position,
   input  logic [hrem_pkg::BYTE_W-1:0] req_byte_value,
   input  logic                        req_report_end,
   input  logic [hrem_pkg::SLOT_W-1:0] req_rule_slot,
   input  logic [hrem_pkg::KIND_W-1:0] req_rule_kind,
   input  logic [hrem_pkg::POS_W-1:0]  req_rule_byte,
   input  logic [hrem_pkg::BYTE_W-1:0] req_rule_argument,
   input  logic [hrem_pkg::DEV_W-1:0]  req_rule_device,
   input  logic [hrem_pkg::EVT_W-1:0]  req_rule_event,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_action,
   output logic [hrem_pkg::DEV_W-1:0]  rsp_dest_device,
   output logic [hrem_pkg::EVT_W-1:0]  rsp_target,
   output logic [hrem_pkg::BYTE_W-1:0] rsp_value,
   output logic                        rsp_final_res
);
   import hrem_pkg::*;

   localparam int RULE_AW  = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;
   localparam int SW       = (RULE_AW > SLOT_W) ? RULE_AW : SLOT_W;
   localparam int IW       = (RULE_AW > CNT_W) ? RULE_AW : CNT_W;
   localparam int WALK_MAX = (RULE_COUNT < MAX_RESULTS) ? RULE_COUNT : MAX_RESULTS;

   // storage
   rule_type          rule_mem [RULE_COUNT];
   rule_type          rule_rd_ff;
   logic [BYTE_W-1:0] last_seen_ff [RULE_COUNT];

   // control and payload registers
   state_type         state_ff, state_in;
   logic [CFG_W-1:0]  active_rules_ff;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  limit_ff, limit_in;
   logic              pend_valid_ff, pend_valid_in;
   result_type        pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff, rsp_in;
   logic              rsp_final_ff, rsp_final_in;

   // datapath
   logic [SW-1:0]      slot_ext;
   logic [RULE_AW-1:0] slot_addr;
   logic               slot_ok;
   logic [IW-1:0]      idx_ext;
   logic [RULE_AW-1:0] walk_addr;
   logic [CNT_W-1:0]   limit_calc;
   logic               last_step;
   logic               out_free;
   logic [BYTE_W-1:0]  rpt_byte;
   eval_type           ev;
   rule_type           rule_wr_data;

   // sequencer outputs
   logic req_xfer;
   logic rule_wr;
   logic rpt_wr;
   logic walk_start;
   logic rule_rd_en;
   logic byte_rd_en;
   logic eval_done;
   logic push;
   logic push_final;

   assign slot_ext   = SW'(req_rule_slot);
   assign slot_addr  = slot_ext[RULE_AW-1:0];
   assign slot_ok    = {1'b0, slot_ext} < (SW+1)'(RULE_COUNT);
   assign idx_ext    = IW'(idx_ff);
   assign walk_addr  = idx_ext[RULE_AW-1:0];
   assign limit_calc = (active_rules_ff > CNT_W'(WALK_MAX)) ? CNT_W'(WALK_MAX)
                                                             : active_rules_ff;
   assign last_step  = (idx_ff + CNT_W'(1)) == limit_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign rule_wr_data.kind = rule_kind_type'(req_rule_kind);
   assign rule_wr_data.pos  = req_rule_byte;
   assign rule_wr_data.arg  = req_rule_argument;
   assign rule_wr_data.dev  = req_rule_device;
   assign rule_wr_data.evt  = req_rule_event;

   hrem_report_mem #(
      .REPORT_BYTES (REPORT_BYTES)
   ) u_report_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rpt_wr),
      .wr_pos  (req_byte_position),
      .wr_data (req_byte_value),
      .rd_en   (byte_rd_en),
      .rd_pos  (rule_rd_ff.pos),
      .rd_data (rpt_byte)
   );

   hrem_rule_eval u_rule_eval (
      .rule     (rule_rd_ff),
      .byte_val (rpt_byte),
      .last     (last_seen_ff[walk_addr]),
      .result   (ev)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (walk_start) state_in = ST_RULE_RD;
         ST_RULE_RD: state_in = ST_BYTE_RD;
         ST_BYTE_RD: state_in = ST_EVAL;
         ST_EVAL: begin
            if (eval_done) state_in = last_step ? ST_FLUSH : ST_RULE_RD;
         end
         ST_FLUSH:   if (!pend_valid_ff || out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall  = 1'b1;
      rule_rd_en = 1'b0;
      byte_rd_en = 1'b0;
      eval_done  = 1'b0;
      push       = 1'b0;
      push_final = 1'b0;
      case (state_ff)
         ST_IDLE:    req_stall = 1'b0;
         ST_RULE_RD: rule_rd_en = 1'b1;
         ST_BYTE_RD: byte_rd_en = 1'b1;
         ST_EVAL: begin
            // a new hit pushes the held one out first; hold it if rsp is full
            eval_done = !(ev.fire && pend_valid_ff) || out_free;
            push      = ev.fire && pend_valid_ff && out_free;
         end
         ST_FLUSH: begin
            push       = pend_valid_ff && out_free;
            push_final = 1'b1;
         end
         default:    req_stall = 1'b1;
      endcase
   end

   assign req_xfer   = req_valid && !req_stall;
   assign rule_wr    = req_xfer && (req_mode == MODE_RULE) && slot_ok;
   assign rpt_wr     = req_xfer && (req_mode == MODE_BYTE);
   assign walk_start = rpt_wr && req_report_end && (limit_calc != '0);

   always_comb begin
      idx_in        = idx_ff;
      limit_in      = limit_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (walk_start) begin
         idx_in   = '0;
         limit_in = limit_calc;
      end else if (eval_done) begin
         idx_in = idx_ff + CNT_W'(1);
      end
      if (eval_done && ev.fire) begin
         pend_valid_in = 1'b1;
         pend_in       = ev.res;
      end else if (push && push_final) begin
         pend_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      rsp_final_in = rsp_final_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_in       = pend_ff;
         rsp_final_in = push_final;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         active_rules_ff <= '0;
         idx_ff          <= '0;
         limit_ff        <= '0;
         pend_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         if (csr_write_enable) active_rules_ff <= csr_write_data;
         idx_ff          <= idx_in;
         limit_ff        <= limit_in;
         pend_valid_ff   <= pend_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff      <= pend_in;
      rsp_ff       <= rsp_in;
      rsp_final_ff <= rsp_final_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RULE_COUNT; i++) last_seen_ff[i] <= '0;
      end else if (rule_wr) begin
         last_seen_ff[slot_addr] <= '0;
      end else if (eval_done) begin
         last_seen_ff[walk_addr] <= ev.last_next;
      end
   end

   always_ff @(posedge clock) begin
      if (rule_wr) begin
         rule_mem[slot_addr] <= rule_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rule_rd_en) begin
         rule_rd_ff <= rule_mem[walk_addr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_action      = rsp_ff.action;
   assign rsp_dest_device = rsp_ff.device;
   assign rsp_target      = rsp_ff.target;
   assign rsp_value       = rsp_ff.value;
   assign rsp_final_res   = rsp_final_ff;

   `HREM_ASSERT_NOW(a_idle_no_pend, clock, reset, state_ff == ST_IDLE, !pend_valid_ff,
      "held result left over after walk")
   `HREM_ASSERT_NOW(a_idx_in_range, clock, reset,
      (state_ff == ST_RULE_RD) || (state_ff == ST_BYTE_RD) || (state_ff == ST_EVAL),
      idx_ff < limit_ff, "walk index past rule limit")
   `HREM_ASSERT_NEXT(a_final_ends_walk, clock, reset, push && push_final,
      (state_ff == ST_IDLE) && !pend_valid_ff && rsp_valid_ff && rsp_final_ff,
      "final result did not close the walk")

endmodule
